### rtl/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg: shared constants and types of the multicast rate selector.
// Holds the nominal rate table, register indexes, command codes and the
// item format that passes between the front end and the back end.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int unsigned NumRatesDef    = 12;
  localparam int unsigned PerFracBitsDef = 16;
  localparam int unsigned RomSlots       = 32;
  localparam int unsigned ThrW           = 24;
  localparam int unsigned RateW          = 4;

  localparam logic [1:0] RegEwmaWeight   = 2'd0;
  localparam logic [1:0] RegPktCurrent   = 2'd1;
  localparam logic [1:0] RegPktNeighbour = 2'd2;
  localparam logic [1:0] RegForcedRate   = 2'd3;

  localparam logic CmdFeedback = 1'b0;
  localparam logic CmdTakeover = 1'b1;

  localparam logic KindRate   = 1'b0;
  localparam logic KindLeader = 1'b1;

  // Nominal rates in half-Mbps units; unused slots read zero.
  function automatic logic [7:0] nominal_rate(input logic [4:0] idx);
    logic [7:0] r;
    case (idx)
      5'd0:    r = 8'd2;
      5'd1:    r = 8'd4;
      5'd2:    r = 8'd11;
      5'd3:    r = 8'd22;
      5'd4:    r = 8'd12;
      5'd5:    r = 8'd18;
      5'd6:    r = 8'd24;
      5'd7:    r = 8'd36;
      5'd8:    r = 8'd48;
      5'd9:    r = 8'd72;
      5'd10:   r = 8'd96;
      5'd11:   r = 8'd104;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // A classified item as queued between front and back end.
  typedef struct packed {
    logic        takeover;
    logic        update;
    logic        last;
    logic [4:0]  idx;
    logic [15:0] sent;
    logic [15:0] received;
    logic [7:0]  ttl;
  } mrs_item_t;

endpackage

### rtl/mrs_front.sv
// ----------------------------------------------------------------------------
// mrs_front: accepts input items and classifies them.
// Decides whether a feedback element updates a rate and with which sent
// count, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module mrs_front
  import mrs_pkg::*;
#(
  parameter int unsigned NumRates = NumRatesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [3:0]  rate_index_i,
  input  logic [15:0] received_count_i,
  input  logic        last_element_i,
  input  logic [7:0]  ttl_value_i,
  input  logic [4:0]  cur_rate_i,
  input  logic [15:0] pkt_current_i,
  input  logic [15:0] pkt_neighbour_i,
  input  logic        busy_i,
  output logic        push_o,
  output mrs_item_t   item_o,
  input  logic        q_full_i
);

  logic [4:0] idx;
  logic       is_cur, is_nb;
  logic       wait_q, wait_d;

  assign idx    = {1'b0, rate_index_i};
  assign is_cur = (idx == cur_rate_i);
  assign is_nb  = ((cur_rate_i != 5'd0) && (idx == cur_rate_i - 5'd1)) ||
                  ((32'(cur_rate_i) + 1 < NumRates) && (idx == cur_rate_i + 5'd1));

  // The current rate only settles once the previous item has finished, so
  // one item is in flight at a time.
  assign in_ready_o = !q_full_i && !busy_i && !wait_q;
  assign push_o     = in_valid_i && in_ready_o;
  assign wait_d     = push_o ? 1'b1 : (wait_q && !busy_i ? 1'b0 : wait_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= 1'b0;
    end else begin
      wait_q <= wait_d;
    end
  end

  always_comb begin
    item_o.takeover = (command_i == CmdTakeover);
    item_o.update   = (32'(idx) < NumRates) && (is_cur || is_nb);
    item_o.last     = last_element_i;
    item_o.idx      = idx;
    item_o.sent     = is_cur ? pkt_current_i : pkt_neighbour_i;
    item_o.received = received_count_i;
    item_o.ttl      = ttl_value_i;
  end

endmodule

### rtl/mrs_back.sv
// ----------------------------------------------------------------------------
// mrs_back: carries out classified items.
// Serial loss division, EWMA smoothing, throughput update, argmax scan over
// the rate table and result output register.
// ----------------------------------------------------------------------------
module mrs_back
  import mrs_pkg::*;
#(
  parameter int unsigned NumRates    = NumRatesDef,
  parameter int unsigned PerFracBits = PerFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  mrs_item_t   q_item_i,
  output logic        pop_o,
  input  logic [15:0] ewma_weight_i,
  input  logic [3:0]  forced_rate_i,
  output logic [4:0]  cur_rate_o,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [3:0]  chosen_rate_o,
  output logic [7:0]  leader_ttl_o
);

  localparam int unsigned F    = PerFracBits;
  localparam int unsigned NumW = 16 + F;
  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam int unsigned IdxW = $clog2(NumRates);
  localparam logic [F-1:0] PerMax = {F{1'b1}};
  // Throughput is kept in Q16 whatever the error rate format is.
  localparam int unsigned ShR  = (F >= 16) ? F - 16 : 0;
  localparam int unsigned ShL  = (F >= 16) ? 0 : 16 - F;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StEwma  = 3'd2;
  localparam logic [2:0] StThr   = 3'd3;
  localparam logic [2:0] StScan  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]       st_q;
  mrs_item_t        it_q;
  logic [NumW-1:0]  quo_q;
  logic [16:0]      rem_q;
  logic [CntW-1:0]  cnt_q;
  logic [F-1:0]     p_q;
  logic [F-1:0]     er_q [NumRates];
  logic [ThrW-1:0]  thr_q [NumRates];
  logic [4:0]       cur_q;
  logic [7:0]       leader_q;
  logic [IdxW-1:0]  scan_q;
  logic             ov_q, kind_q;
  logic [16:0]      rem_sh;
  logic [F-1:0]     er_new;
  logic [F+16:0]    acc;
  logic [F+16:0]    thr_full;
  logic [4:0]       fsat;

  assign cur_rate_o    = cur_q;
  assign busy_o        = (st_q != StIdle) || ov_q;
  assign out_valid_o   = ov_q;
  assign result_kind_o = kind_q;
  assign chosen_rate_o = cur_q[3:0];
  assign leader_ttl_o  = leader_q;
  assign pop_o         = (st_q == StIdle) && !ov_q && q_valid_i;

  assign rem_sh = {rem_q[15:0], quo_q[NumW-1]};
  assign acc = (F+17)'(ewma_weight_i) * (F+17)'(er_q[it_q.idx[IdxW-1:0]])
             + (F+17)'(17'h10000 - 17'(ewma_weight_i)) * (F+17)'(p_q)
             + (F+17)'(32768);
  assign er_new = ((acc >> 16) > (F+17)'(PerMax)) ? PerMax : F'(acc >> 16);
  assign thr_full = (F+17)'(nominal_rate(it_q.idx)) *
                    (((F+17)'(1) << F) - (F+17)'(er_q[it_q.idx[IdxW-1:0]]));
  assign fsat = (32'(forced_rate_i) >= NumRates) ? 5'(NumRates - 1) : {1'b0, forced_rate_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      cur_q    <= 5'd4;
      leader_q <= 8'd0;
      ov_q     <= 1'b0;
      kind_q   <= KindRate;
      for (int i = 0; i < NumRates; i++) begin
        er_q[i]  <= '0;
        thr_q[i] <= '0;
      end
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (pop_o) begin
            it_q <= q_item_i;
            if (q_item_i.takeover) begin
              leader_q <= q_item_i.ttl;
              kind_q   <= KindLeader;
              ov_q     <= 1'b1;
            end else if (q_item_i.update) begin
              quo_q <= NumW'(q_item_i.sent > q_item_i.received ?
                       q_item_i.sent - q_item_i.received : 16'd0) << F;
              rem_q <= '0;
              cnt_q <= CntW'(NumW);
              st_q  <= StDiv;
            end else if (q_item_i.last) begin
              scan_q <= '0;
              st_q   <= StScan;
            end
          end
        end
        StDiv: begin
          // Restoring division, one quotient bit per cycle.
          if (cnt_q != CntW'(0)) begin
            if (rem_sh >= {1'b0, it_q.sent}) begin
              rem_q <= rem_sh - {1'b0, it_q.sent};
              quo_q <= {quo_q[NumW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[NumW-2:0], 1'b0};
            end
            cnt_q <= cnt_q - CntW'(1);
          end else begin
            p_q  <= (it_q.sent == 16'd0 || quo_q > NumW'(PerMax)) ?
                    ((it_q.sent == 16'd0 || quo_q == '0) ? '0 : PerMax) : F'(quo_q);
            st_q <= StEwma;
          end
        end
        StEwma: begin
          er_q[it_q.idx[IdxW-1:0]] <= er_new;
          st_q <= StThr;
        end
        StThr: begin
          thr_q[it_q.idx[IdxW-1:0]] <= ThrW'((thr_full >> ShR) << ShL);
          if (it_q.last) begin
            scan_q <= '0;
            st_q   <= StScan;
          end else begin
            st_q <= StIdle;
          end
        end
        StScan: begin
          if (thr_q[scan_q] > thr_q[cur_q[IdxW-1:0]]) cur_q <= 5'(scan_q);
          if (32'(scan_q) == NumRates - 1) st_q <= StOut;
          else scan_q <= scan_q + IdxW'(1);
        end
        StOut: begin
          if (forced_rate_i != 4'd0) cur_q <= fsat;
          kind_q <= KindRate;
          ov_q   <= 1'b1;
          st_q   <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

### rtl/multicast_rate_selector_core.sv
// ----------------------------------------------------------------------------
// multicast_rate_selector_core: throughput-driven multicast rate selection.
//
//  channel | direction | signals
//  in      | input     | in_valid_i/in_ready_o, command, rate_index, ...
//  out     | output    | out_valid_o/out_ready_i, result_kind, chosen_rate, ...
//  cfg     | input     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i
//
// A feedback element for a tracked rate passes the serial loss divider, EWMA
// smoothing and the throughput update before the next item is accepted; a last
// element adds the argmax scan and result handoff. Other items only pass the
// queue and, for a result, the output register. One item is in flight.
// Reset clears all error rates and throughputs at once. A stalled output
// holds the back end; the front end stops accepting until it drains.
// ----------------------------------------------------------------------------
module multicast_rate_selector_core
  import mrs_pkg::*;
#(
  parameter int unsigned NumRates    = NumRatesDef,
  parameter int unsigned PerFracBits = PerFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [3:0]  rate_index_i,
  input  logic [15:0] received_count_i,
  input  logic        last_element_i,
  input  logic [7:0]  ttl_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [3:0]  chosen_rate_o,
  output logic [7:0]  leader_ttl_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] ewma_q, pcur_q, pnb_q;
  logic [3:0]  forced_q;
  mrs_item_t   item, q_item_q;
  logic        push, pop, qv_q, busy;
  logic [4:0]  cur;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ewma_q   <= 16'd32768;
      pcur_q   <= 16'd70;
      pnb_q    <= 16'd10;
      forced_q <= 4'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegEwmaWeight:   ewma_q   <= cfg_data_i;
        RegPktCurrent:   pcur_q   <= cfg_data_i;
        RegPktNeighbour: pnb_q    <= cfg_data_i;
        RegForcedRate:   forced_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // One-entry queue between front and back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q <= 1'b0;
    end else if (push) begin
      qv_q <= 1'b1;
    end else if (pop) begin
      qv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_item_q <= item;
  end

  mrs_front #(.NumRates(NumRates)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .rate_index_i,
    .received_count_i, .last_element_i, .ttl_value_i,
    .cur_rate_i(cur), .pkt_current_i(pcur_q), .pkt_neighbour_i(pnb_q),
    .busy_i(busy || qv_q), .push_o(push), .item_o(item), .q_full_i(qv_q)
  );

  mrs_back #(.NumRates(NumRates), .PerFracBits(PerFracBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv_q), .q_item_i(q_item_q), .pop_o(pop),
    .ewma_weight_i(ewma_q), .forced_rate_i(forced_q), .cur_rate_o(cur),
    .busy_o(busy), .out_valid_o, .out_ready_i, .result_kind_o,
    .chosen_rate_o, .leader_ttl_o
  );

endmodule

### rtl/mrs_checker.sv
// ----------------------------------------------------------------------------
// mrs_checker: port-level checks of the rate selector.
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module mrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       result_kind_o,
  input logic [3:0] chosen_rate_o,
  input logic [7:0] leader_ttl_o
);

  // A result waiting to be taken holds its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chosen_rate_o)
      && $stable(leader_ttl_o) && $stable(result_kind_o))
    else $error("stalled result changed");

  // The chosen rate stays inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chosen_rate_o < 4'd12)
    else $error("chosen rate out of range");

  // An item is never accepted in the cycle after another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("back-to-back accept");

endmodule

bind multicast_rate_selector_core mrs_checker u_mrs_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .result_kind_o, .chosen_rate_o, .leader_ttl_o
);
